FILE: rtl/btmx_pkg.sv
// Package for the binary trie maximum-xor block.
// Holds default sizes, operation and status codes, and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package btmx_pkg;

  // Default sizes
  localparam int BTMX_KEY_BITS   = 32;
  localparam int BTMX_POOL_NODES = 4096;
  localparam int BTMX_COUNT_BITS = 20;

  // Operation codes on the mode port
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [2:0] STAT_POOL_FULL = 3'd2;
  localparam logic [2:0] STAT_SATURATED = 3'd3;
  localparam logic [2:0] STAT_EMPTY     = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MODIFY,
    ST_QUERY,
    ST_PROBE
  } btmx_state_t;

endpackage

FILE: rtl/binary_trie_max_xor.sv
// Binary trie keeping a multiset of keys and answering maximum-xor queries.
// Single module: sequencer, root registers and node pool memory. Uses btmx_pkg.
//
// A transaction is taken when start is high and busy is low; busy stays high
// while the trie is walked, and the result appears on best_xor and status for
// exactly one cycle with done high. The receiver cannot stall, and a new
// transaction may be started in that same cycle. The walk is paced by the
// single registered read port of the node memory: an add or remove walks the
// path once to check it and once to update it, and a refused one ends after
// the check walk. A query walks the path once, with an extra probe step at
// each level where the opposite child exists and must be probed for its count.
// A query on an empty set and an unused mode never raise busy and show their
// result in the next cycle. Nodes are never freed; the pool starts empty,
// needs no clearing pass, and is ready right after reset.
`timescale 1ns / 1ps

module binary_trie_max_xor
  import btmx_pkg::*;
#(
  parameter int KEY_BITS   = BTMX_KEY_BITS,
  parameter int POOL_NODES = BTMX_POOL_NODES,
  parameter int COUNT_BITS = BTMX_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] key,
  output logic        done,
  output logic [31:0] best_xor,
  output logic [2:0]  status
);

  localparam int IDX_W  = $clog2(POOL_NODES);
  localparam int FREE_W = $clog2(POOL_NODES + 1);
  localparam int LVL_W  = $clog2(KEY_BITS + 1);
  localparam int KB_W   = $clog2(KEY_BITS);
  localparam int NODE_W = 2 * IDX_W + COUNT_BITS;
  localparam int CMP_W  = ((FREE_W > LVL_W) ? FREE_W : LVL_W) + 1;

  // Control and working registers
  btmx_state_t                state, state_next;
  logic                       done_next;
  logic [31:0]                best_xor_next;
  logic [2:0]                 status_next;
  logic [1:0]                 op, op_next;
  logic [KEY_BITS-1:0]        key_r, key_r_next;
  logic [KEY_BITS-1:0]        acc, acc_next;
  logic [LVL_W-1:0]           lvl, lvl_next;
  logic [IDX_W-1:0]           cur, cur_next;
  logic [IDX_W-1:0]           alt, alt_next;
  logic                       fresh, fresh_next;
  logic [IDX_W-1:0]           root_l0, root_l0_next;
  logic [IDX_W-1:0]           root_l1, root_l1_next;
  logic [COUNT_BITS-1:0]      root_count, root_count_next;
  logic [FREE_W-1:0]          next_free, next_free_next;

  // Node pool
  logic [NODE_W-1:0]          mem [POOL_NODES];
  logic [NODE_W-1:0]          rd_data;
  logic                       rd_en, wr_en;
  logic [IDX_W-1:0]           rd_addr, wr_addr;
  logic [NODE_W-1:0]          wr_data;

  // Current node fields and walk helpers
  logic [IDX_W-1:0]           rd_l0, rd_l1, view_l0, view_l1;
  logic [COUNT_BITS-1:0]      rd_cnt, view_cnt, cnt_new;
  logic [KB_W-1:0]            bit_idx;
  logic                       kbit;
  logic [IDX_W-1:0]           c_same, c_other, c_new, new_l0, new_l1;
  logic                       path_gone, pool_full;
  logic [LVL_W-1:0]           miss_val;
  logic [KEY_BITS+31:0]       key_wide;
  logic [KEY_BITS+31:0]       acc_wide;

  assign busy = (state != ST_IDLE);

  assign key_wide = {KEY_BITS'(0), key};
  assign acc_wide = {32'(0), acc};

  assign rd_cnt = rd_data[COUNT_BITS-1:0];
  assign rd_l0  = rd_data[COUNT_BITS +: IDX_W];
  assign rd_l1  = rd_data[COUNT_BITS + IDX_W +: IDX_W];

  // Select the node under the walk: root registers, a fresh node, or memory
  always_comb begin
    if (cur == '0) begin
      view_l0  = root_l0;
      view_l1  = root_l1;
      view_cnt = root_count;
    end else if (fresh) begin
      view_l0  = '0;
      view_l1  = '0;
      view_cnt = '0;
    end else begin
      view_l0  = rd_l0;
      view_l1  = rd_l1;
      view_cnt = rd_cnt;
    end
  end

  assign bit_idx = KB_W'(lvl - LVL_W'(1));
  assign kbit    = key_r[bit_idx];
  assign c_same  = kbit ? view_l1 : view_l0;
  assign c_other = kbit ? view_l0 : view_l1;

  // Check-walk outcome and pool capacity
  assign path_gone = (lvl != '0) && (c_same == '0);
  assign miss_val  = path_gone ? lvl : '0;
  assign pool_full = (CMP_W'(next_free) > CMP_W'(POOL_NODES)) ||
                     (CMP_W'(miss_val) > (CMP_W'(POOL_NODES) - CMP_W'(next_free)));

  // Update values for the modify walk
  assign cnt_new = (op == MODE_ADD) ? (view_cnt + COUNT_BITS'(1))
                                    : (view_cnt - COUNT_BITS'(1));
  assign c_new   = ((op == MODE_ADD) && (c_same == '0)) ? next_free[IDX_W-1:0] : c_same;
  assign new_l0  = (lvl != '0 && !kbit) ? c_new : view_l0;
  assign new_l1  = (lvl != '0 && kbit)  ? c_new : view_l1;

  // Advance the sequencer
  always_comb begin
    state_next      = state;
    done_next       = 1'b0;
    best_xor_next   = best_xor;
    status_next     = status;
    op_next         = op;
    key_r_next      = key_r;
    acc_next        = acc;
    lvl_next        = lvl;
    cur_next        = cur;
    alt_next        = alt;
    fresh_next      = fresh;
    root_l0_next    = root_l0;
    root_l1_next    = root_l1;
    root_count_next = root_count;
    next_free_next  = next_free;
    rd_en           = 1'b0;
    rd_addr         = c_same;
    wr_en           = 1'b0;
    wr_addr         = cur;
    wr_data         = {new_l1, new_l0, cnt_new};

    case (state)
      ST_IDLE: begin
        if (start) begin
          op_next    = mode;
          key_r_next = key_wide[KEY_BITS-1:0];
          acc_next   = '0;
          lvl_next   = LVL_W'(KEY_BITS);
          cur_next   = '0;
          fresh_next = 1'b0;
          case (mode)
            MODE_ADD, MODE_REMOVE: begin
              state_next = ST_CHECK;
            end
            MODE_QUERY: begin
              if (root_count == '0) begin
                done_next     = 1'b1;
                status_next   = STAT_EMPTY;
                best_xor_next = '0;
              end else begin
                state_next = ST_QUERY;
              end
            end
            default: begin
              done_next     = 1'b1;
              status_next   = STAT_OK;
              best_xor_next = '0;
            end
          endcase
        end
      end

      // Walk the key's path to find where it ends
      ST_CHECK: begin
        if (lvl == '0 || path_gone) begin
          lvl_next   = LVL_W'(KEY_BITS);
          cur_next   = '0;
          fresh_next = 1'b0;
          best_xor_next = '0;
          if (op == MODE_ADD) begin
            if (root_count == '1) begin
              state_next  = ST_IDLE;
              done_next   = 1'b1;
              status_next = STAT_SATURATED;
            end else if (pool_full) begin
              state_next  = ST_IDLE;
              done_next   = 1'b1;
              status_next = STAT_POOL_FULL;
            end else begin
              state_next = ST_MODIFY;
            end
          end else begin
            if (path_gone || view_cnt == '0) begin
              state_next  = ST_IDLE;
              done_next   = 1'b1;
              status_next = STAT_NOT_FOUND;
            end else begin
              state_next = ST_MODIFY;
            end
          end
        end else begin
          cur_next = c_same;
          rd_en    = 1'b1;
          rd_addr  = c_same;
          lvl_next = lvl - LVL_W'(1);
        end
      end

      // Write back each node on the path with its count adjusted
      ST_MODIFY: begin
        if (cur == '0) begin
          root_l0_next    = new_l0;
          root_l1_next    = new_l1;
          root_count_next = cnt_new;
        end else begin
          wr_en = 1'b1;
        end
        if (lvl == '0) begin
          state_next    = ST_IDLE;
          done_next     = 1'b1;
          status_next   = STAT_OK;
          best_xor_next = '0;
        end else begin
          if ((op == MODE_ADD) && (c_same == '0)) begin
            next_free_next = next_free + FREE_W'(1);
            fresh_next     = 1'b1;
          end
          cur_next = c_new;
          rd_en    = 1'b1;
          rd_addr  = c_new;
          lvl_next = lvl - LVL_W'(1);
        end
      end

      // Prefer the opposite child; probe its count when it exists
      ST_QUERY: begin
        if (lvl == '0) begin
          state_next    = ST_IDLE;
          done_next     = 1'b1;
          status_next   = STAT_OK;
          best_xor_next = acc_wide[31:0];
        end else if (c_other == '0) begin
          cur_next = c_same;
          rd_en    = 1'b1;
          rd_addr  = c_same;
          lvl_next = lvl - LVL_W'(1);
        end else begin
          cur_next   = c_other;
          alt_next   = c_same;
          rd_en      = 1'b1;
          rd_addr    = c_other;
          state_next = ST_PROBE;
        end
      end

      // Take the opposite child if populated, else fall back to the same bit
      ST_PROBE: begin
        state_next = ST_QUERY;
        lvl_next   = lvl - LVL_W'(1);
        if (rd_cnt != '0) begin
          acc_next[bit_idx] = 1'b1;
        end else begin
          cur_next = alt;
          rd_en    = 1'b1;
          rd_addr  = alt;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      root_l0    <= '0;
      root_l1    <= '0;
      root_count <= '0;
      next_free  <= FREE_W'(1);
    end else begin
      state      <= state_next;
      done       <= done_next;
      root_l0    <= root_l0_next;
      root_l1    <= root_l1_next;
      root_count <= root_count_next;
      next_free  <= next_free_next;
    end
  end

  // Hold working and result registers
  always_ff @(posedge clk) begin
    best_xor <= best_xor_next;
    status   <= status_next;
    op       <= op_next;
    key_r    <= key_r_next;
    acc      <= acc_next;
    lvl      <= lvl_next;
    cur      <= cur_next;
    alt      <= alt_next;
    fresh    <= fresh_next;
  end

  // Node pool: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Result is shown only once the walk has finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe while walk still active");

  // Allocation never runs past the pool
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(next_free) <= CMP_W'(POOL_NODES))
    else $error("node allocation overran the pool");

  // A write and a read in the same cycle never hit the same node
  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("node memory read and write collide");

  // The pool is only written for a pool node, never for the root slot
  a_wr_nonroot: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ((wr_addr != '0) && (state == ST_MODIFY)))
    else $error("node write outside the update walk");

  // Add and remove always occupy the block after acceptance
  a_busy_walk: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_ADD || mode == MODE_REMOVE)) |=> (busy && !done))
    else $error("add or remove finished without a walk");

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for binary_trie_max_xor: adds, removes and max-xor queries on a keyed multiset.
// A built-in trie predictor checks every result as it arrives.
// Depends on btmx_pkg and binary_trie_max_xor.
`timescale 1ns / 1ps

module tb_top;
  import btmx_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned COUNT_LIMIT = (1 << BTMX_COUNT_BITS) - 1;
  localparam int KEY_POOL_SIZE = 40;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] key;
    int          idle_pct;
  } trie_cmd_t;

  typedef struct {
    logic [31:0] best_xor;
    logic [2:0]  status;
  } trie_answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  mode = MODE_ADD;
  logic [31:0] key = 32'd0;
  logic        busy;
  logic        done;
  logic [31:0] best_xor;
  logic [2:0]  status;

  trie_cmd_t    pending_ops[$];
  trie_answer_t predicted_answers[$];
  logic [31:0]  key_pool[KEY_POOL_SIZE];
  int           err_count = 0;
  int           stall_cycles = 0;

  // Shadow trie: node 0 is the root, pool nodes are 1..POOL_NODES-1
  int unsigned trie_link[BTMX_POOL_NODES][2];
  int unsigned trie_count[BTMX_POOL_NODES];
  int unsigned next_node = 1;

  binary_trie_max_xor i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .mode     (mode),
    .key      (key),
    .done     (done),
    .best_xor (best_xor),
    .status   (status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one transaction to the shadow trie and return what the block should answer
  function automatic trie_answer_t trie_apply(input logic [1:0] op, input logic [31:0] k);
    trie_answer_t ans;
    int unsigned  node;
    int unsigned  child;
    int unsigned  missing;
    int           lvl;
    ans.best_xor = 32'd0;
    ans.status = STAT_OK;
    node = 0;
    missing = 0;
    case (op)
      MODE_ADD: begin
        for (lvl = 31; lvl >= 0; lvl--) begin
          child = trie_link[node][k[lvl]];
          if (child == 0) begin
            missing = lvl + 1;
            break;
          end
          node = child;
        end
        if (trie_count[0] >= COUNT_LIMIT) begin
          ans.status = STAT_SATURATED;
        end else if (next_node > BTMX_POOL_NODES || missing > BTMX_POOL_NODES - next_node) begin
          ans.status = STAT_POOL_FULL;
        end else begin
          node = 0;
          trie_count[0]++;
          for (lvl = 31; lvl >= 0; lvl--) begin
            child = trie_link[node][k[lvl]];
            if (child == 0) begin
              child = next_node;
              next_node++;
              trie_link[child][0] = 0;
              trie_link[child][1] = 0;
              trie_count[child] = 0;
              trie_link[node][k[lvl]] = child;
            end
            node = child;
            trie_count[node]++;
          end
        end
      end
      MODE_REMOVE: begin
        for (lvl = 31; lvl >= 0; lvl--) begin
          child = trie_link[node][k[lvl]];
          if (child == 0) begin
            ans.status = STAT_NOT_FOUND;
            break;
          end
          node = child;
        end
        if (ans.status == STAT_OK && trie_count[node] == 0) ans.status = STAT_NOT_FOUND;
        if (ans.status == STAT_OK) begin
          node = 0;
          trie_count[0]--;
          for (lvl = 31; lvl >= 0; lvl--) begin
            node = trie_link[node][k[lvl]];
            trie_count[node]--;
          end
        end
      end
      MODE_QUERY: begin
        if (trie_count[0] == 0) begin
          ans.status = STAT_EMPTY;
        end else begin
          // Prefer the opposite bit whenever that branch still holds keys
          for (lvl = 31; lvl >= 0; lvl--) begin
            child = trie_link[node][~k[lvl]];
            if (child != 0 && trie_count[child] > 0) begin
              ans.best_xor[lvl] = 1'b1;
              node = child;
            end else begin
              node = trie_link[node][k[lvl]];
            end
          end
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  task automatic push_op(input logic [1:0] op, input logic [31:0] k, input int idle_pct);
    trie_cmd_t cmd;
    cmd.mode = op;
    cmd.key = k;
    cmd.idle_pct = idle_pct;
    pending_ops.push_back(cmd);
  endtask

  // Mostly keys from a shared pool so the multiset grows and shrinks; some fresh keys
  task automatic push_random_op(input int idle_pct);
    int          pick;
    logic [31:0] pool_key;
    pick = $urandom_range(0, 99);
    pool_key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    if (pick < 31) push_op(MODE_ADD, pool_key, idle_pct);
    else if (pick < 35) push_op(MODE_ADD, $urandom, idle_pct);
    else if (pick < 56) push_op(MODE_REMOVE, pool_key, idle_pct);
    else if (pick < 60) push_op(MODE_REMOVE, $urandom, idle_pct);
    else if (pick < 78) push_op(MODE_QUERY, pool_key, idle_pct);
    else if (pick < 96) push_op(MODE_QUERY, $urandom, idle_pct);
    else push_op(MODE_UNUSED, $urandom, idle_pct);
  endtask

  task report_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] %s mismatch: got %h expected %h", $realtime, field, got, want);
    err_count++;
  endtask

  // Driver: predict on each accepted transaction, then present the next one or idle
  always @(posedge clk) begin
    trie_cmd_t head;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        head = pending_ops.pop_front();
        predicted_answers.push_back(trie_apply(head.mode, head.key));
      end
      if (pending_ops.size() > 0 &&
          $urandom_range(0, 99) >= pending_ops[0].idle_pct) begin
        start <= 1'b1;
        mode <= pending_ops[0].mode;
        key <= pending_ops[0].key;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result strobe with the oldest prediction
  always @(posedge clk) begin
    trie_answer_t want;
    if (!rst && done) begin
      if (predicted_answers.size() == 0) begin
        $display("[%0t] unexpected result: best_xor %h status %0d", $realtime, best_xor,
                 status);
        err_count++;
      end else begin
        want = predicted_answers.pop_front();
        if (best_xor !== want.best_xor) report_mismatch("best_xor", best_xor, want.best_xor);
        if (status !== want.status) report_mismatch("status", {29'd0, status},
                                                    {29'd0, want.status});
      end
    end
  end

  // Watchdog: abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("binary_trie_max_xor regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int phase_idle[4];
    int ph;
    int n;
    phase_idle = '{0, 59, 0, 21};

    // Build a key pool with shared prefixes so the node pool lasts
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (n = 2; n < 10; n++) key_pool[n] = $urandom;
    for (n = 10; n < KEY_POOL_SIZE; n++) begin
      key_pool[n] = key_pool[$urandom_range(0, n - 1)] ^ ($urandom & 32'h0000_FFFF);
    end

    // Directed: empty set, unused mode, extreme keys, duplicates, stale paths
    push_op(MODE_QUERY, 32'h0000_0000, 0);
    push_op(MODE_REMOVE, 32'h0000_0000, 0);
    push_op(MODE_UNUSED, 32'hFFFF_FFFF, 0);
    push_op(MODE_ADD, 32'h0000_0000, 0);
    push_op(MODE_ADD, 32'hFFFF_FFFF, 0);
    push_op(MODE_ADD, 32'h0000_0000, 0);
    push_op(MODE_QUERY, 32'h0000_0000, 0);
    push_op(MODE_QUERY, 32'hFFFF_FFFF, 0);
    push_op(MODE_QUERY, 32'h8000_0000, 0);
    push_op(MODE_REMOVE, 32'hFFFF_FFFF, 0);
    push_op(MODE_REMOVE, 32'hFFFF_FFFF, 0);
    push_op(MODE_QUERY, 32'hFFFF_FFFF, 0);
    push_op(MODE_QUERY, 32'h0000_0000, 0);
    push_op(MODE_REMOVE, 32'h0000_0000, 0);
    push_op(MODE_REMOVE, 32'h0000_0000, 0);
    push_op(MODE_QUERY, 32'h1234_5678, 0);
    push_op(MODE_REMOVE, 32'h0000_0000, 0);
    push_op(MODE_ADD, 32'hAAAA_AAAA, 0);
    push_op(MODE_ADD, 32'h5555_5555, 0);
    push_op(MODE_ADD, 32'h0F0F_0F0F, 0);
    push_op(MODE_QUERY, 32'h5A5A_5A5A, 0);
    push_op(MODE_REMOVE, 32'h1234_5678, 0);
    push_op(MODE_UNUSED, 32'h0000_0000, 0);
    push_op(MODE_QUERY, 32'h0000_0001, 0);

    // Random phases with different sender idling
    for (ph = 0; ph < 4; ph++) begin
      for (n = 0; n < 350; n++) push_random_op(phase_idle[ph]);
    end
    // Fresh keys until the node pool runs out, then keep working the pool keys
    for (n = 0; n < 200; n++) begin
      if ($urandom_range(0, 3) == 0) push_random_op(59);
      else push_op(MODE_ADD, $urandom, 59);
    end
    for (n = 0; n < 100; n++) push_random_op(21);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() > 0 || predicted_answers.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("binary_trie_max_xor regression: pass");
    end else begin
      $display("binary_trie_max_xor regression: fail");
    end
    $finish;
  end

endmodule
